// ===== hw/rtl/xte_pkg.sv =====
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types and character constants for the XML text escape encoder.
// ----------------------------------------------------------------------------
package xte_pkg;

   // longest escaped run, "&quot;" / "&apos;" / "&#255;"
   localparam int MaxRun = 6;

   // characters that take part in escaping
   localparam logic [7:0] ChLt    = 8'h3C;
   localparam logic [7:0] ChGt    = 8'h3E;
   localparam logic [7:0] ChAmp   = 8'h26;
   localparam logic [7:0] ChQuot  = 8'h22;
   localparam logic [7:0] ChApos  = 8'h27;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChSemi  = 8'h3B;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTilde = 8'h7E;

   typedef logic [2:0] run_len_type;
   typedef logic [2:0] run_idx_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_last;
   } rsp_type;

   typedef struct packed {
      logic [MaxRun-1:0][7:0] text;
      run_len_type            len;
   } run_type;

endpackage

// ===== hw/rtl/xte_chan_if.sv =====
// ----------------------------------------------------------------------------
// xte_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface xte_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/xte_in_stage.sv =====
// ----------------------------------------------------------------------------
// xte_in_stage
// Input register: holds one request until its whole escaped run is sent.
// ----------------------------------------------------------------------------
module xte_in_stage (
   input  logic             clock,
   input  logic             reset,
   xte_chan_if.sink         req_chan,
   input  logic             take,
   output logic             in_vld,
   output xte_pkg::req_type in_item
);

   logic             vld_ff;
   logic             vld_in;
   xte_pkg::req_type item_ff;
   logic             accept;

   // refill in the same cycle the held request retires
   assign req_chan.ready = !vld_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign vld_in         = accept || (vld_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_chan.data;
      end
   end

   assign in_vld  = vld_ff;
   assign in_item = item_ff;

endmodule

// ===== hw/rtl/xte_encode.sv =====
// ----------------------------------------------------------------------------
// xte_encode
// Maps one text byte to its escaped run of 1 to 6 bytes and the run length.
// ----------------------------------------------------------------------------
module xte_encode (
   input  logic [7:0]       in_byte,
   output xte_pkg::run_type run
);

   logic [1:0]  hundreds;
   logic [6:0]  rest;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [7:0]  dig_h;
   logic [7:0]  dig_t;
   logic [7:0]  dig_o;

   // decimal digits: compare-subtract for hundreds, reciprocal multiply for tens
   always_comb begin
      if (in_byte >= 8'd200) begin
         hundreds = 2'd2;
         rest     = 7'(in_byte - 8'd200);
      end else if (in_byte >= 8'd100) begin
         hundreds = 2'd1;
         rest     = 7'(in_byte - 8'd100);
      end else begin
         hundreds = 2'd0;
         rest     = in_byte[6:0];
      end
      prod  = 15'(rest) * 15'd205;
      tens  = prod[14:11];
      ones  = 4'(rest - 7'(tens) * 7'd10);
      dig_h = xte_pkg::ChZero | {6'd0, hundreds};
      dig_t = xte_pkg::ChZero | {4'd0, tens};
      dig_o = xte_pkg::ChZero | {4'd0, ones};
   end

   always_comb begin
      run.text    = '0;
      run.len     = 3'd1;
      run.text[0] = xte_pkg::ChAmp;
      unique case (in_byte)
         xte_pkg::ChLt: begin
            run.text[1] = "l";
            run.text[2] = "t";
            run.text[3] = xte_pkg::ChSemi;
            run.len     = 3'd4;
         end
         xte_pkg::ChGt: begin
            run.text[1] = "g";
            run.text[2] = "t";
            run.text[3] = xte_pkg::ChSemi;
            run.len     = 3'd4;
         end
         xte_pkg::ChAmp: begin
            run.text[1] = "a";
            run.text[2] = "m";
            run.text[3] = "p";
            run.text[4] = xte_pkg::ChSemi;
            run.len     = 3'd5;
         end
         xte_pkg::ChQuot: begin
            run.text[1] = "q";
            run.text[2] = "u";
            run.text[3] = "o";
            run.text[4] = "t";
            run.text[5] = xte_pkg::ChSemi;
            run.len     = 3'd6;
         end
         xte_pkg::ChApos: begin
            run.text[1] = "a";
            run.text[2] = "p";
            run.text[3] = "o";
            run.text[4] = "s";
            run.text[5] = xte_pkg::ChSemi;
            run.len     = 3'd6;
         end
         xte_pkg::ChLf: begin
            run.text[1] = xte_pkg::ChHash;
            run.text[2] = "1";
            run.text[3] = "0";
            run.text[4] = xte_pkg::ChSemi;
            run.len     = 3'd5;
         end
         xte_pkg::ChCr: begin
            run.text[1] = xte_pkg::ChHash;
            run.text[2] = "1";
            run.text[3] = "3";
            run.text[4] = xte_pkg::ChSemi;
            run.len     = 3'd5;
         end
         xte_pkg::ChTab: begin
            run.text[1] = xte_pkg::ChHash;
            run.text[2] = "9";
            run.text[3] = xte_pkg::ChSemi;
            run.len     = 3'd4;
         end
         default: begin
            if (in_byte < xte_pkg::ChSpace || in_byte > xte_pkg::ChTilde) begin
               run.text[1] = xte_pkg::ChHash;
               if (in_byte >= 8'd100) begin
                  run.text[2] = dig_h;
                  run.text[3] = dig_t;
                  run.text[4] = dig_o;
                  run.text[5] = xte_pkg::ChSemi;
                  run.len     = 3'd6;
               end else if (in_byte >= 8'd10) begin
                  run.text[2] = dig_t;
                  run.text[3] = dig_o;
                  run.text[4] = xte_pkg::ChSemi;
                  run.len     = 3'd5;
               end else begin
                  run.text[2] = dig_o;
                  run.text[3] = xte_pkg::ChSemi;
                  run.len     = 3'd4;
               end
            end else begin
               run.text[0] = in_byte;
               run.len     = 3'd1;
            end
         end
      endcase
   end

endmodule

// ===== hw/rtl/xte_out_stage.sv =====
// ----------------------------------------------------------------------------
// xte_out_stage
// Steps through the escaped run of the held request and feeds the response
// register one byte per cycle while the response is not stalled.
// ----------------------------------------------------------------------------
module xte_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  xte_pkg::req_type in_item,
   input  xte_pkg::run_type run,
   output logic             take,
   xte_chan_if.source       rsp_chan
);

   xte_pkg::run_idx_type idx_ff;
   xte_pkg::run_idx_type idx_in;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   xte_pkg::rsp_type     rsp_ff;
   xte_pkg::rsp_type     rsp_in;
   logic                 load;
   logic                 emit;
   logic                 last;

   assign load = !rsp_vld_ff || rsp_chan.ready;
   assign emit = in_vld && load;
   assign last = (idx_ff == run.len - 3'd1);
   assign take = emit && last;

   assign rsp_in.out_byte  = run.text[idx_ff];
   assign rsp_in.run_last  = last;
   assign rsp_in.text_last = last && in_item.string_end;

   assign rsp_vld_in = emit || (rsp_vld_ff && !rsp_chan.ready);

   // rewind when the run retires, advance on every other byte sent
   always_comb begin
      if (take) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      in_vld |-> (idx_ff < run.len))
      else $error("run index beyond run length");

   a_text_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.text_last) |-> rsp_ff.run_last)
      else $error("text_last without run_last");

   a_rewind_on_take: assert property (@(posedge clock) disable iff (reset)
      take |=> (idx_ff == '0))
      else $error("run index not rewound after last byte");

   a_hold_mid_run: assert property (@(posedge clock) disable iff (reset)
      (emit && !last) |=> (in_vld && idx_ff != '0))
      else $error("request dropped in the middle of its run");

endmodule

// ===== hw/rtl/xml_text_escape_encoder_core.sv =====
// ----------------------------------------------------------------------------
// xml_text_escape_encoder_core
// XML text escaping: one text byte in, its escaped run of 1 to 6 bytes out.
// ----------------------------------------------------------------------------
//  channel    dir   payload                           handshake
//  req_chan   in    in_byte[7:0], string_end          valid / ready
//  rsp_chan   out   out_byte[7:0], run_last, text_last valid / ready
//
//  A request is taken every cycle for plain bytes while the response side
//  keeps up. An escaped byte is sent as a run of 4 to 6 output bytes by
//  the single response register; its request is held until the run ends.
//  A request passes the input register, then the response register.
//  Reset is synchronous and empties both registers.
//  A stalled response holds its byte; the held request waits with it.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder_core (
   input  logic       clock,
   input  logic       reset,
   xte_chan_if.sink   req_chan,
   xte_chan_if.source rsp_chan
);

   logic             in_vld;
   logic             take;
   xte_pkg::req_type in_item;
   xte_pkg::run_type run;

   xte_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_vld   (in_vld),
      .in_item  (in_item)
   );

   xte_encode u_encode (
      .in_byte (in_item.in_byte),
      .run     (run)
   );

   xte_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld),
      .in_item  (in_item),
      .run      (run),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule
